// ===== rtl/brb_pkg.sv =====
`default_nettype none

package brb_pkg;

   localparam int CLIENT_W = 3;
   localparam int DATA_W   = 64;
   localparam int POS_W    = 4;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_ADD    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_WRITTEN    = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_DELIVERED  = 3'd2,
      STAT_NACK       = 3'd3,
      STAT_ADDED      = 3'd4,
      STAT_REMOVED    = 3'd5,
      STAT_CLIENT_ERR = 3'd6
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [DATA_W-1:0]  read_data;
      logic [POS_W-1:0]   position;
      logic               last;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/brb_req_if.sv =====
`default_nettype none

interface brb_req_if;
   logic                             valid;
   logic                             ready;
   brb_pkg::op_type                  operation;
   logic [brb_pkg::CLIENT_W-1:0]     client;
   logic [brb_pkg::DATA_W-1:0]       write_data;

   modport source (output valid, output operation, output client, output write_data,
                   input ready);
   modport sink   (input valid, input operation, input client, input write_data,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/brb_rsp_if.sv =====
`default_nettype none

interface brb_rsp_if;
   logic                             valid;
   logic                             ready;
   brb_pkg::status_type              status;
   logic [brb_pkg::DATA_W-1:0]       read_data;
   logic [brb_pkg::POS_W-1:0]        position;
   logic                             last;

   modport source (output valid, output status, output read_data, output position,
                   output last, input ready);
   modport sink   (input valid, input status, input read_data, input position,
                   input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/brb_ram.sv =====
`default_nettype none

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/broadcast_ring_buffer.sv =====
// a write, full, add, nack, error or empty-remove word is registered after the lookup state reads the client entry
// a delivered read also passes the take state, where the slot memory read returns the message
// a remove with pending words passes lookup and take for its first word, then one per cycle while
// the response side accepts; one request in flight: no new request is taken until its last word
// is issued, and a waiting word held back by the response side stalls the block
// reset clears write pointer, counts and reader set at once; no memory clearing pass
`default_nettype none

module broadcast_ring_buffer #(
   parameter int RING_DEPTH   = 16,
   parameter int MAX_CLIENTS  = 8,
   parameter int MESSAGE_BITS = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   brb_req_if.sink   req_ch,
   brb_rsp_if.source rsp_ch
);

   localparam int SLOT_AW = $clog2(RING_DEPTH);
   localparam int CLI_AW  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int SEQ_W   = SLOT_AW + 1;
   localparam int FREE_W  = $clog2(RING_DEPTH + 1);
   localparam int RDR_W   = $clog2(MAX_CLIENTS + 1);
   localparam int SLOT_W  = MESSAGE_BITS + RDR_W;
   localparam int CENT_W  = SLOT_AW + SEQ_W;
   localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(RING_DEPTH - 1);
   localparam logic [FREE_W-1:0]  FREE_MAX  = FREE_W'(RING_DEPTH);
   localparam logic [SLOT_AW:0]   DRAIN_MAX = (SLOT_AW + 1)'(RING_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_LOOKUP = 3'b010,
      S_TAKE   = 3'b100
   } state_type;

   function automatic logic [SLOT_AW-1:0] next_slot(input logic [SLOT_AW-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   state_type                       state_ff, state_in;
   brb_pkg::op_type                 op_ff, op_in;
   logic [brb_pkg::CLIENT_W-1:0]    cli_ff, cli_in;
   logic [MESSAGE_BITS-1:0]         data_ff, data_in;
   logic [SLOT_AW-1:0]              wp_ff, wp_in;
   logic [FREE_W-1:0]               free_ff, free_in;
   logic [RDR_W-1:0]                readers_ff, readers_in;
   logic [SEQ_W-1:0]                wseq_ff, wseq_in;
   logic [MAX_CLIENTS-1:0]          active_ff, active_in;
   logic [SLOT_AW-1:0]              rptr_ff, rptr_in;
   logic [SEQ_W-1:0]                cseq_ff, cseq_in;
   logic [SLOT_AW-1:0]              drain_ff, drain_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   brb_pkg::rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                            slot_we, slot_re;
   logic [SLOT_AW-1:0]              slot_waddr, slot_raddr;
   logic [SLOT_W-1:0]               slot_wdata, slot_rdata;
   logic                            cli_we, cli_re;
   logic [CLI_AW-1:0]               cli_waddr, cli_raddr;
   logic [CENT_W-1:0]               cli_wdata, cli_rdata;

   logic [CLI_AW-1:0]               cidx;
   logic                            cli_ok, cli_act;
   logic [SLOT_AW-1:0]              ent_rptr, rptr_next;
   logic [SEQ_W-1:0]                ent_seq, pend_look, pend_take;
   logic [MESSAGE_BITS-1:0]         slot_msg;
   logic [RDR_W-1:0]                slot_ref, ref_dec;
   logic                            take_final, out_free, go_take;
   brb_pkg::rsp_word_type           look_word;

   brb_ram #(.WIDTH(SLOT_W), .DEPTH(RING_DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   brb_ram #(.WIDTH(CENT_W), .DEPTH(MAX_CLIENTS)) u_client_ram (
      .clock   (clock),
      .wr_en   (cli_we),
      .wr_addr (cli_waddr),
      .wr_data (cli_wdata),
      .rd_en   (cli_re),
      .rd_addr (cli_raddr),
      .rd_data (cli_rdata)
   );

   assign cidx       = CLI_AW'(cli_ff);
   assign cli_ok     = 32'(cli_ff) < MAX_CLIENTS;
   assign cli_act    = cli_ok && active_ff[cidx];
   assign ent_rptr   = cli_rdata[CENT_W-1:SEQ_W];
   assign ent_seq    = cli_rdata[SEQ_W-1:0];
   assign pend_look  = wseq_ff - ent_seq;
   assign pend_take  = wseq_ff - cseq_ff;
   assign slot_ref   = slot_rdata[RDR_W-1:0];
   assign slot_msg   = slot_rdata[SLOT_W-1:RDR_W];
   assign ref_dec    = (slot_ref != '0) ? slot_ref - 1'b1 : '0;
   assign rptr_next  = next_slot(rptr_ff);
   assign take_final = (op_ff == brb_pkg::OP_READ)
                    || !((pend_take > SEQ_W'(1)) && ({1'b0, drain_ff} < DRAIN_MAX));
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // outcome of a request once its client entry is back
   always_comb begin
      look_word.status    = brb_pkg::STAT_CLIENT_ERR;
      look_word.read_data = '0;
      look_word.position  = '0;
      look_word.last      = 1'b1;
      go_take             = 1'b0;
      case (op_ff)
         brb_pkg::OP_WRITE: begin
            if (free_ff == '0) begin
               look_word.status = brb_pkg::STAT_FULL;
            end else begin
               look_word.status = brb_pkg::STAT_WRITTEN;
            end
         end
         brb_pkg::OP_ADD: begin
            if (cli_ok && !cli_act) begin
               look_word.status   = brb_pkg::STAT_ADDED;
               look_word.position = brb_pkg::POS_W'(wp_ff);
            end
         end
         brb_pkg::OP_READ: begin
            if (cli_act) begin
               if (pend_look == '0) begin
                  look_word.status = brb_pkg::STAT_NACK;
               end else begin
                  go_take = 1'b1;
               end
            end
         end
         brb_pkg::OP_REMOVE: begin
            if (cli_act) begin
               if (pend_look == '0) begin
                  look_word.status = brb_pkg::STAT_REMOVED;
               end else begin
                  go_take = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cli_in       = cli_ff;
      data_in      = data_ff;
      wp_in        = wp_ff;
      free_in      = free_ff;
      readers_in   = readers_ff;
      wseq_in      = wseq_ff;
      active_in    = active_ff;
      rptr_in      = rptr_ff;
      cseq_in      = cseq_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_word_in  = rsp_word_ff;
      slot_we      = 1'b0;
      slot_waddr   = wp_ff;
      slot_wdata   = {data_ff, readers_ff};
      slot_re      = 1'b0;
      slot_raddr   = ent_rptr;
      cli_we       = 1'b0;
      cli_waddr    = cidx;
      cli_wdata    = {wp_ff, wseq_ff};
      cli_re       = 1'b0;
      cli_raddr    = CLI_AW'(req_ch.client);

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               cli_in   = req_ch.client;
               data_in  = req_ch.write_data[MESSAGE_BITS-1:0];
               cli_re   = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (go_take) begin
               slot_re  = 1'b1;
               rptr_in  = ent_rptr;
               cseq_in  = ent_seq;
               drain_in = '0;
               state_in = S_TAKE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = look_word;
               state_in     = S_IDLE;
               case (look_word.status)
                  brb_pkg::STAT_WRITTEN: begin
                     slot_we = 1'b1;
                     if (readers_ff != '0) begin
                        free_in = free_ff - 1'b1;
                     end
                     wseq_in = wseq_ff + 1'b1;
                     wp_in   = next_slot(wp_ff);
                  end
                  brb_pkg::STAT_ADDED: begin
                     cli_we          = 1'b1;
                     active_in[cidx] = 1'b1;
                     readers_in      = readers_ff + 1'b1;
                  end
                  brb_pkg::STAT_REMOVED: begin
                     active_in[cidx] = 1'b0;
                     if (readers_ff != '0) begin
                        readers_in = readers_ff - 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TAKE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (take_final && (op_ff == brb_pkg::OP_REMOVE)) begin
                  rsp_word_in.status = brb_pkg::STAT_REMOVED;
               end else begin
                  rsp_word_in.status = brb_pkg::STAT_DELIVERED;
               end
               rsp_word_in.read_data = brb_pkg::DATA_W'(slot_msg);
               rsp_word_in.position  = brb_pkg::POS_W'(rptr_ff);
               rsp_word_in.last      = take_final;
               slot_we    = 1'b1;
               slot_waddr = rptr_ff;
               slot_wdata = {slot_msg, ref_dec};
               if ((slot_ref == RDR_W'(1)) && (free_ff < FREE_MAX)) begin
                  free_in = free_ff + 1'b1;
               end
               rptr_in  = rptr_next;
               cseq_in  = cseq_ff + 1'b1;
               drain_in = drain_ff + 1'b1;
               if (take_final) begin
                  state_in = S_IDLE;
                  if (op_ff == brb_pkg::OP_READ) begin
                     cli_we    = 1'b1;
                     cli_wdata = {rptr_next, cseq_ff + 1'b1};
                  end else begin
                     active_in[cidx] = 1'b0;
                     if (readers_ff != '0) begin
                        readers_in = readers_ff - 1'b1;
                     end
                  end
               end else begin
                  slot_re    = 1'b1;
                  slot_raddr = rptr_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         free_ff      <= FREE_MAX;
         readers_ff   <= '0;
         wseq_ff      <= '0;
         active_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
         free_ff      <= free_in;
         readers_ff   <= readers_in;
         wseq_ff      <= wseq_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cli_ff      <= cli_in;
      data_ff     <= data_in;
      rptr_ff     <= rptr_in;
      cseq_ff     <= cseq_in;
      drain_ff    <= drain_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_word_ff.status;
   assign rsp_ch.read_data = rsp_word_ff.read_data;
   assign rsp_ch.position  = rsp_word_ff.position;
   assign rsp_ch.last      = rsp_word_ff.last;

`ifndef NO_ASSERTIONS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_MAX)
      else $error("free slot count above ring depth");

   a_reader_count: assert property (@(posedge clock) disable iff (reset)
      readers_ff == RDR_W'($countones(active_ff)))
      else $error("reader total out of step with active set");

   a_mid_word: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last |-> rsp_ch.status == brb_pkg::STAT_DELIVERED)
      else $error("non-final word is not a delivery");

   a_take_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TAKE |-> pend_take != '0)
      else $error("slot fetch with nothing pending");
`endif

endmodule

`default_nettype wire
